// File: hw/rtl/dqse_pkg.sv
// Package for the dual quadrature speed estimator.
// Shared constants, register indexes and item kind codes; no dependencies.
`default_nettype none

package dqse_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int LANES       = 2;
    localparam int SPEED_WIDTH = 32;
    localparam int SCALE_WIDTH = 32;
    localparam int WSIZE_WIDTH = 7;
    localparam int CFG_IDX_W   = 1;

    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [WSIZE_WIDTH-1:0] WSIZE_RESET = 7'd15;
    localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 32'd2240;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 1'd1;

    localparam logic KIND_EDGE   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [SPEED_WIDTH-1:0] SPEED_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [SPEED_WIDTH-1:0] SPEED_NEG_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

// File: hw/rtl/dual_quadrature_speed_estimator.sv
// Dual quadrature speed estimator: 2x edge decode, moving-average ring, Q16.16 scaling.
// Depends on dqse_pkg.
`default_nettype none

// Edge items update a saturating tick count per wheel; sample items take both counts,
// push them into one shared ring memory (left and right side by side, registered read)
// and update running sums, then scale each sum by speed_scale with saturation.
// One item is accepted per cycle while input ready is high. A sample's result goes
// through the memory read, the sum update, the magnitude stage, the multiplier and
// the result queue, in that order, before it is valid. Input ready drops only while
// eight results are in flight or waiting. A window_size write empties the ring
// through a fill count, so there is no clearing pass after reset or after the write.
module dual_quadrature_speed_estimator #(
    parameter int MAX_WINDOW  = dqse_pkg::MAX_WINDOW_DEF,
    parameter int COUNT_WIDTH = dqse_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    input  wire logic [7:0]                           i_s_axis_tdata,  // wheel, edge_rising, level_b
    input  wire logic                                 i_s_axis_tuser,  // kind
    output logic                                      o_m_axis_tvalid,
    input  wire logic                                 i_m_axis_tready,
    output logic [2*dqse_pkg::SPEED_WIDTH-1:0]        o_m_axis_tdata,  // left_speed, right_speed
    input  wire logic                                 i_cfg_we,
    input  wire logic [dqse_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [dqse_pkg::SCALE_WIDTH-1:0]     i_cfg_wdata
);

    localparam int LANES = dqse_pkg::LANES;
    localparam int CW    = COUNT_WIDTH;
    localparam int DW    = LANES * CW;
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int CMPW  = (WW > dqse_pkg::WSIZE_WIDTH) ? WW : dqse_pkg::WSIZE_WIDTH;
    localparam int SW    = CW + $clog2(MAX_WINDOW) + 1;
    localparam int MW    = (SW > 33) ? SW : 33;
    localparam int SPW   = dqse_pkg::SPEED_WIDTH;
    localparam int SCW   = dqse_pkg::SCALE_WIDTH;
    localparam int FD    = dqse_pkg::FIFO_DEPTH;
    localparam int FAW   = dqse_pkg::FIFO_AW;

    localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};

    // configuration
    logic [dqse_pkg::WSIZE_WIDTH-1:0] r_win_size;
    logic [SCW-1:0]                   r_scale;
    logic                             cfg_win_wr;

    // ring control
    logic [AW-1:0]   r_pos;
    logic [WW-1:0]   r_fill;
    logic [CMPW-1:0] ws_ext;
    logic [WW-1:0]   eff_win;
    logic [AW-1:0]   cur_pos;
    logic [WW-1:0]   nxt_pos_w;
    logic [AW-1:0]   n_pos;
    logic            cur_ok;

    // input handshake
    logic in_acc;
    logic in_edge;
    logic in_sample;
    logic edge_up;
    logic in_wheel;

    logic signed [CW-1:0] r_cnt [LANES];

    // ring memory and pipeline
    logic [DW-1:0] mem [MAX_WINDOW];
    logic [DW-1:0] r_rdata;

    logic          r_s1_vld;
    logic [AW-1:0] r_s1_addr;
    logic [DW-1:0] r_s1_new;
    logic          r_s1_ok;
    logic          r_s1_fwd;
    logic [DW-1:0] r_s1_fwd_data;
    logic [DW-1:0] s1_new;

    logic signed [CW-1:0] old_v [LANES];
    logic signed [CW-1:0] new_v [LANES];
    logic signed [SW-1:0] r_sum [LANES];
    logic signed [SW-1:0] n_sum [LANES];

    logic           r_s2_vld;
    logic [SW-1:0]  mag_v   [LANES];
    logic [MW-1:0]  mag_ext [LANES];

    logic           r_s3_vld;
    logic           r_s3_neg [LANES];
    logic           r_s3_big [LANES];
    logic [31:0]    r_s3_mag [LANES];

    logic           r_s4_vld;
    logic           r_s4_neg [LANES];
    logic           r_s4_sat [LANES];
    logic [63:0]    r_s4_prod[LANES];
    logic [SPW-1:0] spd      [LANES];

    // result queue
    logic [LANES*SPW-1:0] r_fifo [FD];
    logic [FAW-1:0]       r_wp;
    logic [FAW-1:0]       r_rp;
    logic [FAW:0]         r_fcnt;
    logic [FAW:0]         r_used;
    logic                 out_pop;

    assign o_s_axis_tready = (r_used < (FAW+1)'(FD));
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign in_edge   = in_acc && (i_s_axis_tuser == dqse_pkg::KIND_EDGE);
    assign in_sample = in_acc && (i_s_axis_tuser == dqse_pkg::KIND_SAMPLE);
    assign in_wheel  = i_s_axis_tdata[0];
    assign edge_up   = i_s_axis_tdata[1] ^ i_s_axis_tdata[2];

    assign o_m_axis_tvalid = (r_fcnt != '0);
    assign o_m_axis_tdata  = r_fifo[r_rp];
    assign out_pop         = o_m_axis_tvalid && i_m_axis_tready;

    assign cfg_win_wr = i_cfg_we && (i_cfg_idx == dqse_pkg::REG_WINDOW_SIZE);

    always_comb begin
        ws_ext = CMPW'(r_win_size);
        if (ws_ext == '0) begin
            eff_win = WW'(1);
        end else if (ws_ext > CMPW'(MAX_WINDOW)) begin
            eff_win = WW'(MAX_WINDOW);
        end else begin
            eff_win = WW'(ws_ext);
        end
        cur_pos   = (WW'(r_pos) >= eff_win) ? '0 : r_pos;
        nxt_pos_w = WW'(cur_pos) + WW'(1);
        n_pos     = (nxt_pos_w >= eff_win) ? '0 : AW'(nxt_pos_w);
        cur_ok    = (WW'(cur_pos) < r_fill);
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            s1_new[l*CW +: CW] = r_cnt[l];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= dqse_pkg::WSIZE_RESET;
            r_scale    <= dqse_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dqse_pkg::REG_WINDOW_SIZE: r_win_size <= i_cfg_wdata[dqse_pkg::WSIZE_WIDTH-1:0];
                dqse_pkg::REG_SPEED_SCALE: r_scale    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // tick counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LANES; l++) r_cnt[l] <= '0;
        end else if (in_sample) begin
            for (int l = 0; l < LANES; l++) r_cnt[l] <= '0;
        end else if (in_edge) begin
            for (int l = 0; l < LANES; l++) begin
                if (in_wheel == 1'(l)) begin
                    if (edge_up) begin
                        if (r_cnt[l] != CNT_MAX) r_cnt[l] <= r_cnt[l] + CW'(1);
                    end else begin
                        if (r_cnt[l] != CNT_MIN) r_cnt[l] <= r_cnt[l] - CW'(1);
                    end
                end
            end
        end
    end

    // ring position and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_win_wr) begin
            r_pos  <= '0;
            r_fill <= '0;
        end else if (in_sample) begin
            r_pos <= n_pos;
            if (r_fill < WW'(MAX_WINDOW)) r_fill <= r_fill + WW'(1);
        end
    end

    // ring memory: read at acceptance, write back in the cycle after
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[cur_pos];
        if (r_s1_vld) mem[r_s1_addr] <= r_s1_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_sample;
        end
        r_s1_addr     <= cur_pos;
        r_s1_new      <= s1_new;
        r_s1_ok       <= cur_ok;
        r_s1_fwd      <= r_s1_vld && (r_s1_addr == cur_pos);
        r_s1_fwd_data <= r_s1_new;
    end

    // running sums
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            new_v[l] = r_s1_new[l*CW +: CW];
            if (r_s1_fwd) begin
                old_v[l] = r_s1_fwd_data[l*CW +: CW];
            end else if (r_s1_ok) begin
                old_v[l] = r_rdata[l*CW +: CW];
            end else begin
                old_v[l] = '0;
            end
            n_sum[l] = r_sum[l] - SW'(old_v[l]) + SW'(new_v[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_win_wr) begin
            for (int l = 0; l < LANES; l++) r_sum[l] <= '0;
        end else if (r_s1_vld) begin
            for (int l = 0; l < LANES; l++) r_sum[l] <= n_sum[l];
        end
    end

    // magnitude, multiply, saturate
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            mag_v[l]   = r_sum[l][SW-1] ? SW'(-r_sum[l]) : SW'(r_sum[l]);
            mag_ext[l] = MW'(mag_v[l]);
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (r_s4_neg[l]) begin
                if (r_s4_sat[l] || (r_s4_prod[l] >= 64'h8000_0000)) begin
                    spd[l] = dqse_pkg::SPEED_NEG_MIN;
                end else begin
                    spd[l] = SPW'(-r_s4_prod[l][31:0]);
                end
            end else begin
                if (r_s4_sat[l] || (r_s4_prod[l] > 64'h7FFF_FFFF)) begin
                    spd[l] = dqse_pkg::SPEED_POS_MAX;
                end else begin
                    spd[l] = r_s4_prod[l][31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
        for (int l = 0; l < LANES; l++) begin
            r_s3_neg[l]  <= r_sum[l][SW-1];
            r_s3_big[l]  <= (mag_ext[l][MW-1:32] != '0);
            r_s3_mag[l]  <= mag_ext[l][31:0];
            r_s4_neg[l]  <= r_s3_neg[l];
            r_s4_sat[l]  <= r_s3_big[l] && (r_scale != '0);
            r_s4_prod[l] <= 64'(r_s3_mag[l]) * 64'(r_scale);
        end
    end

    // result queue and credit count
    always_ff @(posedge i_clk) begin
        if (r_s4_vld) begin
            for (int l = 0; l < LANES; l++) r_fifo[r_wp][l*SPW +: SPW] <= spd[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fcnt <= '0;
            r_used <= '0;
        end else begin
            if (r_s4_vld) r_wp <= r_wp + FAW'(1);
            if (out_pop)  r_rp <= r_rp + FAW'(1);
            r_fcnt <= r_fcnt + (FAW+1)'(r_s4_vld) - (FAW+1)'(out_pop);
            r_used <= r_used + (FAW+1)'(in_sample) - (FAW+1)'(out_pop);
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/tb_dual_quadrature_speed_estimator.sv
// Self-checking testbench for dual_quadrature_speed_estimator: bursty edge and sample items,
// a stalling result port, config changes between phases and a scoreboard class that predicts
// both filtered speeds. Depends on dqse_pkg and the estimator RTL.
module tb_dual_quadrature_speed_estimator;
    import dqse_pkg::*;

    typedef struct packed {
        logic level_b;
        logic edge_rising;
        logic wheel;
    } edge_fields_t;

    class speed_scoreboard;
        const longint CNT_MAX = (longint'(1) <<< (COUNT_WIDTH_DEF - 1)) - 1;
        const longint CNT_MIN = -((longint'(1) <<< (COUNT_WIDTH_DEF - 1)) - 1) - 1;

        bit [WSIZE_WIDTH-1:0] win_size;
        bit [SCALE_WIDTH-1:0] scale;
        longint               ticks[2];
        longint               ring[2][MAX_WINDOW_DEF];
        longint               ring_sum[2];
        int unsigned          slot;
        bit [2*SPEED_WIDTH-1:0] expected_speeds[$];
        int                   errors;

        function new();
            win_size = WSIZE_RESET;
            scale    = SCALE_RESET;
            ticks[0] = 0;
            ticks[1] = 0;
            errors   = 0;
            clear_rings();
        endfunction

        function void clear_rings();
            for (int s = 0; s < 2; s++) begin
                for (int k = 0; k < MAX_WINDOW_DEF; k++) ring[s][k] = 0;
                ring_sum[s] = 0;
            end
            slot = 0;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [SCALE_WIDTH-1:0] data);
            if (idx == REG_WINDOW_SIZE) begin
                win_size = data[WSIZE_WIDTH-1:0];
                clear_rings();
            end else if (idx == REG_SPEED_SCALE) begin
                scale = data;
            end
        endfunction

        function bit [SPEED_WIDTH-1:0] scale_sum(longint total);
            bit        neg;
            bit [63:0] mag;
            bit [63:0] prod;
            neg = total < 0;
            mag = neg ? 64'(-total) : 64'(total);
            if (scale == 0 || mag == 0) return '0;
            if (mag >= 64'h1_0000_0000) prod = '1;
            else prod = mag * {32'b0, scale};
            if (neg) begin
                if (prod >= 64'h8000_0000) return SPEED_NEG_MIN;
                prod = -prod;
                return prod[SPEED_WIDTH-1:0];
            end
            if (prod > 64'h7FFF_FFFF) return SPEED_POS_MAX;
            return prod[SPEED_WIDTH-1:0];
        endfunction

        function void note_item(logic kind, edge_fields_t f);
            bit          up;
            int unsigned w;
            int unsigned p;
            if (kind == KIND_EDGE) begin
                up = f.edge_rising ? !f.level_b : f.level_b;
                if (up) ticks[f.wheel] = (ticks[f.wheel] >= CNT_MAX) ? CNT_MAX : ticks[f.wheel] + 1;
                else    ticks[f.wheel] = (ticks[f.wheel] <= CNT_MIN) ? CNT_MIN : ticks[f.wheel] - 1;
                return;
            end
            if (win_size == 0) w = 1;
            else if (win_size > MAX_WINDOW_DEF) w = MAX_WINDOW_DEF;
            else w = win_size;
            p = slot;
            if (p >= w) p = 0;
            for (int s = 0; s < 2; s++) begin
                ring_sum[s] = ring_sum[s] - ring[s][p] + ticks[s];
                ring[s][p]  = ticks[s];
                ticks[s]    = 0;
            end
            p++;
            if (p >= w) p = 0;
            slot = p;
            expected_speeds.insert(expected_speeds.size(),
                                   {scale_sum(ring_sum[1]), scale_sum(ring_sum[0])});
        endfunction

        function void check_speeds(bit [2*SPEED_WIDTH-1:0] got);
            bit [2*SPEED_WIDTH-1:0] want;
            if (expected_speeds.size() == 0) begin
                $error("unexpected result item: tdata %h", got);
                errors++;
                return;
            end
            want = expected_speeds[0];
            expected_speeds.delete(0);
            if (got[31:0] !== want[31:0]) begin
                $error("left_speed mismatch: expected %0d, actual %0d",
                       $signed(want[31:0]), $signed(got[31:0]));
                errors++;
            end
            if (got[63:32] !== want[63:32]) begin
                $error("right_speed mismatch: expected %0d, actual %0d",
                       $signed(want[63:32]), $signed(got[63:32]));
                errors++;
            end
        endfunction

        function int pending();
            return expected_speeds.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_s_axis_tvalid = 1'b0;
    logic                       o_s_axis_tready;
    logic [7:0]                 i_s_axis_tdata = '0;  // wheel, edge_rising, level_b
    logic                       i_s_axis_tuser = 1'b0;  // kind
    logic                       o_m_axis_tvalid;
    logic                       i_m_axis_tready = 1'b0;
    logic [2*SPEED_WIDTH-1:0]   o_m_axis_tdata;  // left_speed, right_speed
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [SCALE_WIDTH-1:0]     i_cfg_wdata = '0;

    speed_scoreboard sb;
    int rx_mode = 0;
    int rx_run = 0;
    int up_bias[2];
    int sample_odds;

    dual_quadrature_speed_estimator u_top (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) sb.check_speeds(o_m_axis_tdata);
    end

    // result port: runs of always ready, coin flip, mostly stalled, fully stalled
    always @(negedge i_clk) begin
        if (rx_run == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_run  = (rx_mode == 3) ? $urandom_range(1, 30) : $urandom_range(4, 60);
        end
        rx_run--;
        case (rx_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            2: i_m_axis_tready <= ($urandom_range(0, 5) == 0);
            default: i_m_axis_tready <= 1'b0;
        endcase
    end

    initial begin
        #3_000_000;
        $display("tb_dual_quadrature_speed_estimator: FAIL");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(logic kind, edge_fields_t f);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = kind;
        i_s_axis_tdata  = {5'b0, f};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_item(kind, f);
        @(negedge i_clk);
    endtask

    task automatic send_edge(logic wheel, logic up, logic rising);
        edge_fields_t f;
        f.wheel       = wheel;
        f.edge_rising = rising;
        f.level_b     = rising ? !up : up;
        send_item(KIND_EDGE, f);
    endtask

    task automatic send_random_item();
        edge_fields_t f;
        logic         wheel;
        if ($urandom_range(1, sample_odds) == 1) begin
            f = edge_fields_t'(3'($urandom_range(0, 7)));
            send_item(KIND_SAMPLE, f);
        end else begin
            wheel = 1'($urandom_range(0, 1));
            send_edge(wheel, $urandom_range(0, 99) < up_bias[wheel],
                      1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_bursts(int n_items);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < 2; k++) up_bias[k] = 10 + 40 * $urandom_range(0, 2);
            for (int k = 0; k < burst && sent < n_items; k++) begin
                send_random_item();
                sent++;
            end
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 3);
                2: gap = $urandom_range(1, 12);
                default: gap = $urandom_range(0, 1);
            endcase
            if (gap > 0) begin
                i_s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [SCALE_WIDTH-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty sample, every edge decode case, samples right behind edges
        send_item(KIND_SAMPLE, '0);
        for (int k = 0; k < 8; k++) send_item(KIND_EDGE, edge_fields_t'(k));
        send_item(KIND_SAMPLE, '0);
        repeat (3) send_edge(1'b0, 1'b1, 1'b1);
        repeat (2) send_edge(1'b1, 1'b0, 1'b0);
        send_item(KIND_SAMPLE, edge_fields_t'(3'b111));
        send_edge(1'b1, 1'b1, 1'b0);
        send_item(KIND_SAMPLE, edge_fields_t'(3'b010));
        send_item(KIND_SAMPLE, edge_fields_t'(3'b101));
        drain();

        for (int phase = 1; phase <= 8; phase++) begin
            case (phase)
                1: begin
                    write_cfg(REG_WINDOW_SIZE, 32'd1);
                    write_cfg(REG_SPEED_SCALE, 32'h0001_0000);
                end
                2: begin
                    write_cfg(REG_WINDOW_SIZE, 32'd64);
                    write_cfg(REG_SPEED_SCALE, 32'hFFFF_FFFF);
                end
                3: write_cfg(REG_SPEED_SCALE, 32'd0);  // ring kept across a scale-only change
                4: begin
                    write_cfg(REG_WINDOW_SIZE, 32'd0);
                    write_cfg(REG_SPEED_SCALE, 32'd1);
                end
                5: begin
                    write_cfg(REG_WINDOW_SIZE, 32'd127);
                    write_cfg(REG_SPEED_SCALE, 32'd2240);
                end
                6: begin
                    write_cfg(REG_WINDOW_SIZE, 32'hFFFF_FF85);
                    write_cfg(REG_SPEED_SCALE, 32'h0100_0000);
                end
                7: begin
                    write_cfg(REG_WINDOW_SIZE, 32'd65);
                    write_cfg(REG_SPEED_SCALE, $urandom());
                end
                default: begin
                    write_cfg(REG_WINDOW_SIZE, $urandom_range(2, 63));
                    write_cfg(REG_SPEED_SCALE, 32'h8000_0000);
                end
            endcase
            sample_odds = $urandom_range(3, 12);
            run_bursts(100);
            drain();
            run_bursts(100);
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_dual_quadrature_speed_estimator: PASS");
        end else begin
            $display("tb_dual_quadrature_speed_estimator: FAIL");
        end
        $finish;
    end

endmodule

// File: dual_quadrature_speed_estimator.f
hw/rtl/dqse_pkg.sv
hw/rtl/dual_quadrature_speed_estimator.sv
tb/sv/tb_dual_quadrature_speed_estimator.sv
